@@ rtl/ptld3_pkg.sv @@
`timescale 1ns / 1ps
package ptld3_pkg;

  // Field widths of the item formats
  localparam int COORD_WIDTH = 24;  // signed Q16.8 positions
  localparam int DIR_WIDTH   = 20;  // signed Q4.16 direction
  localparam int OUT_WIDTH   = 24;  // Q16.8 results

  // Root search covers bits 24..0, then saturates
  localparam int ROOT_BITS = 25;

  localparam logic [OUT_WIDTH-1:0] RAD_MAX      = 24'hFF_FFFF;
  localparam logic [OUT_WIDTH-1:0] PROJ_POS_MAX = 24'h7F_FFFF;
  localparam logic [OUT_WIDTH-1:0] PROJ_NEG_MAX = 24'h80_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [DIR_WIDTH-1:0]   dir_x;
    logic signed [DIR_WIDTH-1:0]   dir_y;
    logic signed [DIR_WIDTH-1:0]   dir_z;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic        [OUT_WIDTH-1:0] radial_distance;
    logic signed [OUT_WIDTH-1:0] axial_projection;
    logic                        degenerate;
  } out_item_t;

endpackage

@@ rtl/point_to_line_distance_3d.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                  | Handshake
// ---------+------------------------+-------------------------------------
// input    | start, busy, in_data   | taken when start high and busy low
// result   | out_valid, out_data    | one-cycle strobe, cannot be held off
//
// One item may enter every cycle; busy is always low.
// The pipeline has 7 arithmetic stages, 25 root stages (one result bit
// each, both roots side by side) and the output register.
// Synchronous active-low reset clears only the valid bits of the pipeline.
// The pipeline never stalls: the receiver takes every result as it appears.
module point_to_line_distance_3d (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ptld3_pkg::in_item_t   in_data,
  output logic                  out_valid,
  output ptld3_pkg::out_item_t  out_data
);
  import ptld3_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;      // point - start
  localparam int PW  = DW + DIR_WIDTH;       // d * v
  localparam int CW  = PW + 1;               // cross component
  localparam int MW  = PW + 2;               // dot, and magnitude width
  localparam int H   = (MW + 1) / 2;         // low half for squaring
  localparam int HW  = MW - H;               // high half
  localparam int SQW = 2 * MW;
  localparam int NW  = SQW + 2;              // root numerators
  localparam int VW  = 2 * DIR_WIDTH;
  localparam int D2W = VW + 2;               // |dir|^2
  localparam int RB  = ROOT_BITS;
  localparam int SW  = D2W + RB;             // r * D2
  localparam int WA  = D2W + 2 * RB + 1;
  localparam int W   = ((NW > WA) ? NW : WA) + 1;

  assign busy = 1'b0;

  // Stage 1: differences, direction
  logic                 s1_vld_r;
  logic signed [DW-1:0] d_r [3];
  logic signed [DIR_WIDTH-1:0] v_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
  end

  always_ff @(posedge clk) begin
    d_r[0] <= DW'(in_data.point_x) - DW'(in_data.start_x);
    d_r[1] <= DW'(in_data.point_y) - DW'(in_data.start_y);
    d_r[2] <= DW'(in_data.point_z) - DW'(in_data.start_z);
    v_r[0] <= in_data.dir_x;
    v_r[1] <= in_data.dir_y;
    v_r[2] <= in_data.dir_z;
  end

  // Stage 2: all d_i * v_j products and v_i squared
  logic                 s2_vld_r;
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [VW-1:0] vsq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= PW'(d_r[i]) * PW'(v_r[j]);
      end
      vsq_r[i] <= VW'(v_r[i]) * VW'(v_r[i]);
    end
  end

  // Stage 3: cross product, dot product, direction length squared
  logic                  s3_vld_r;
  logic signed [CW-1:0]  cross_r [3];
  logic signed [MW-1:0]  dot_r;
  logic        [D2W-1:0] d2_s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    cross_r[0] <= CW'(prod_r[1][2]) - CW'(prod_r[2][1]);
    cross_r[1] <= CW'(prod_r[2][0]) - CW'(prod_r[0][2]);
    cross_r[2] <= CW'(prod_r[0][1]) - CW'(prod_r[1][0]);
    dot_r      <= MW'(prod_r[0][0]) + MW'(prod_r[1][1]) + MW'(prod_r[2][2]);
    d2_s3_r    <= D2W'(unsigned'(vsq_r[0])) + D2W'(unsigned'(vsq_r[1]))
                + D2W'(unsigned'(vsq_r[2]));
  end

  // Stage 4: magnitudes, sign of the projection, zero direction
  logic                  s4_vld_r;
  logic        [MW-1:0]  mag_r [4];
  logic                  dneg_s4_r;
  logic                  degen_s4_r;
  logic        [D2W-1:0] d2_s4_r;
  logic signed [MW-1:0]  sval [4];

  always_comb begin
    for (int i = 0; i < 3; i++) sval[i] = MW'(cross_r[i]);
    sval[3] = dot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      mag_r[i] <= sval[i][MW-1] ? MW'(-sval[i]) : MW'(sval[i]);
    end
    dneg_s4_r  <= dot_r[MW-1];
    degen_s4_r <= (d2_s3_r == '0);
    d2_s4_r    <= d2_s3_r;
  end

  // Stage 5: squares as half-width partial products
  logic                  s5_vld_r;
  logic [2*HW-1:0]       hh_r [4];
  logic [H+HW-1:0]       hl_r [4];
  logic [2*H-1:0]        ll_r [4];
  logic                  dneg_s5_r;
  logic                  degen_s5_r;
  logic [D2W-1:0]        d2_s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hh_r[i] <= (2*HW)'(mag_r[i][MW-1:H]) * (2*HW)'(mag_r[i][MW-1:H]);
      hl_r[i] <= (H+HW)'(mag_r[i][MW-1:H]) * (H+HW)'(mag_r[i][H-1:0]);
      ll_r[i] <= (2*H)'(mag_r[i][H-1:0]) * (2*H)'(mag_r[i][H-1:0]);
    end
    dneg_s5_r  <= dneg_s4_r;
    degen_s5_r <= degen_s4_r;
    d2_s5_r    <= d2_s4_r;
  end

  // Stage 6: recombine squares
  logic            s6_vld_r;
  logic [SQW-1:0]  sq_r [4];
  logic            dneg_s6_r;
  logic            degen_s6_r;
  logic [D2W-1:0]  d2_s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= (SQW'(hh_r[i]) << (2*H)) + (SQW'(hl_r[i]) << (H+1))
               + SQW'(ll_r[i]);
    end
    dneg_s6_r  <= dneg_s5_r;
    degen_s6_r <= degen_s5_r;
    d2_s6_r    <= d2_s5_r;
  end

  // Stage 7 and root stages: index 0 holds the numerators,
  // index k+1 the state after result bit RB-1-k. Lane 0 radial, lane 1 axial.
  logic           rt_vld_r   [RB+1];
  logic [W-1:0]   rem_r      [RB+1][2];
  logic [SW-1:0]  acc_r      [RB+1][2];
  logic [RB-1:0]  root_r     [RB+1][2];
  logic           dneg_r     [RB+1];
  logic           degen_r    [RB+1];
  logic [D2W-1:0] d2_r       [RB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) rt_vld_r[0] <= 1'b0;
    else        rt_vld_r[0] <= s6_vld_r;
  end

  always_ff @(posedge clk) begin
    rem_r[0][0]  <= W'(NW'(sq_r[0]) + NW'(sq_r[1]) + NW'(sq_r[2]));
    rem_r[0][1]  <= W'(sq_r[3]);
    acc_r[0][0]  <= '0;
    acc_r[0][1]  <= '0;
    root_r[0][0] <= '0;
    root_r[0][1] <= '0;
    dneg_r[0]    <= dneg_s6_r;
    degen_r[0]   <= degen_s6_r;
    d2_r[0]      <= d2_s6_r;
  end

  for (genvar k = 0; k < RB; k++) begin : g_root
    localparam int B = RB - 1 - k;
    logic [W-1:0]  trial [2];
    logic          fit   [2];

    // Setting bit B costs (2*r*2^B + 2^2B) * D2 out of the remainder
    always_comb begin
      for (int j = 0; j < 2; j++) begin
        trial[j] = (W'(acc_r[k][j]) << (B + 1)) + (W'(d2_r[k]) << (2 * B));
        fit[j]   = (trial[j] <= rem_r[k][j]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) rt_vld_r[k+1] <= 1'b0;
      else        rt_vld_r[k+1] <= rt_vld_r[k];
    end

    always_ff @(posedge clk) begin
      for (int j = 0; j < 2; j++) begin
        if (fit[j]) begin
          rem_r[k+1][j]  <= rem_r[k][j] - trial[j];
          acc_r[k+1][j]  <= acc_r[k][j] + (SW'(d2_r[k]) << B);
          root_r[k+1][j] <= root_r[k][j] | (RB'(1) << B);
        end else begin
          rem_r[k+1][j]  <= rem_r[k][j];
          acc_r[k+1][j]  <= acc_r[k][j];
          root_r[k+1][j] <= root_r[k][j];
        end
      end
      dneg_r[k+1]  <= dneg_r[k];
      degen_r[k+1] <= degen_r[k];
      d2_r[k+1]    <= d2_r[k];
    end
  end

  // Output: saturate, sign, zero-direction case
  logic [RB-1:0]        rad_q;
  logic [RB-1:0]        prj_q;
  logic [OUT_WIDTH-1:0] rad_sat;
  logic [OUT_WIDTH-1:0] prj_mag;
  out_item_t            out_nxt;

  always_comb begin
    rad_q   = root_r[RB][0];
    prj_q   = root_r[RB][1];
    rad_sat = (rad_q > RB'(RAD_MAX)) ? RAD_MAX : rad_q[OUT_WIDTH-1:0];
    if (dneg_r[RB]) begin
      prj_mag = (prj_q > RB'(PROJ_NEG_MAX)) ? PROJ_NEG_MAX : prj_q[OUT_WIDTH-1:0];
    end else begin
      prj_mag = (prj_q > RB'(PROJ_POS_MAX)) ? PROJ_POS_MAX : prj_q[OUT_WIDTH-1:0];
    end
    out_nxt.degenerate = degen_r[RB];
    if (degen_r[RB]) begin
      out_nxt.radial_distance  = '0;
      out_nxt.axial_projection = '0;
    end else begin
      out_nxt.radial_distance  = rad_sat;
      out_nxt.axial_projection = dneg_r[RB] ? OUT_WIDTH'(-prj_mag) : prj_mag;
    end
  end

  logic out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= rt_vld_r[RB];
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
